FILE: rtl/bit_aligned_pattern_finder_macros.svh
// ----------------------------------------------------------------------------
// bit_aligned_pattern_finder_macros.svh
// Assertion macros shared by the pattern finder checks.
// ----------------------------------------------------------------------------
`ifndef BIT_ALIGNED_PATTERN_FINDER_MACROS_SVH
`define BIT_ALIGNED_PATTERN_FINDER_MACROS_SVH

// same-cycle implication
`define BAPF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pattern finder check failed");

// next-cycle implication
`define BAPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pattern finder check failed");

`endif

FILE: rtl/bapf_pkg.sv
// ----------------------------------------------------------------------------
// bapf_pkg
// Widths, defaults and register indexes of the bit-aligned pattern finder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bapf_pkg;

   localparam int MAX_PATTERN_BYTES_DEF = 8;
   localparam int BYTE_W                = 8;
   localparam int PATTERN_W             = 64;
   localparam int LENGTH_W              = 4;
   localparam int OFFSET_W              = 32;
   localparam int CSR_ADDR_W            = 1;
   localparam int ALIGNMENTS            = 8;

   localparam logic [LENGTH_W-1:0] LENGTH_RESET = 4'd4;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_MATCH_PATTERN  = 1'b0,
      REG_PATTERN_LENGTH = 1'b1
   } csr_index_type;

endpackage

FILE: rtl/bit_aligned_pattern_finder.sv
// ----------------------------------------------------------------------------
// bit_aligned_pattern_finder
// Treats a byte stream as a bit string (MSB first) and reports the earliest
// bit offset at which a 1..8 byte pattern completes in each new byte.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  req     | in  | tvalid/tready      | tdata: data_byte, tuser: restart
//  rsp     | out | tvalid/tready      | tdata: match_offset
//  csr     | in  | csr_we (no ready)  | csr_addr, csr_wdata
//
//  One beat per cycle while req_tready is high; each result is registered.
//  History, bit count and all eight alignment compares update at acceptance.
//  Output register plus one skid entry; req_tready drops only when both hold.
//  Synchronous active-high reset clears history, count, pattern and valids.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bit_aligned_pattern_finder #(
   parameter int MAX_PATTERN_BYTES = bapf_pkg::MAX_PATTERN_BYTES_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [bapf_pkg::BYTE_W-1:0]             req_tdata,   // [7:0] data_byte
   input  logic                                    req_tuser,   // [0] restart
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [bapf_pkg::OFFSET_W-1:0]           rsp_tdata,   // [31:0] match_offset
   input  logic                                    csr_we,
   input  logic [bapf_pkg::CSR_ADDR_W-1:0]         csr_addr,
   input  logic [bapf_pkg::PATTERN_W-1:0]          csr_wdata
);

   localparam int HistDepth = MAX_PATTERN_BYTES + 1;
   localparam int StreamW   = bapf_pkg::BYTE_W * HistDepth;
   localparam int ThrW      = $clog2(StreamW);
   localparam int ByteW     = bapf_pkg::BYTE_W;
   localparam int OffW      = bapf_pkg::OFFSET_W;
   localparam int LenW      = bapf_pkg::LENGTH_W;
   localparam int NumAlign  = bapf_pkg::ALIGNMENTS;

   // configuration
   logic [bapf_pkg::PATTERN_W-1:0] match_pattern_ff;
   logic [LenW-1:0]                pattern_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_pattern_ff  <= '0;
         pattern_length_ff <= bapf_pkg::LENGTH_RESET;
      end else if (csr_we) begin
         unique case (bapf_pkg::csr_index_type'(csr_addr))
            bapf_pkg::REG_MATCH_PATTERN:  match_pattern_ff  <= csr_wdata;
            bapf_pkg::REG_PATTERN_LENGTH: pattern_length_ff <= csr_wdata[LenW-1:0];
            default: ;
         endcase
      end
   end

   // stream state
   logic [ByteW-1:0] history_ff [HistDepth];
   logic [ByteW-1:0] history_in [HistDepth];
   logic [OffW-1:0]  bits_ff;
   logic [OffW-1:0]  bits_in;
   logic [OffW-1:0]  bits_base;

   logic req_accept;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      history_in[0] = req_tdata;
      for (int i = 1; i < HistDepth; i++) begin
         history_in[i] = req_tuser ? '0 : history_ff[i-1];
      end
      bits_base = req_tuser ? '0 : bits_ff;
      if (bits_base > ('1 - OffW'(ByteW))) begin
         bits_in = '1;
      end else begin
         bits_in = bits_base + OffW'(ByteW);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff <= '0;
         for (int i = 0; i < HistDepth; i++) begin
            history_ff[i] <= '0;
         end
      end else if (req_accept) begin
         bits_ff <= bits_in;
         for (int i = 0; i < HistDepth; i++) begin
            history_ff[i] <= history_in[i];
         end
      end
   end

   // alignment compare
   logic [LenW-1:0]  len_used;
   logic [ByteW-1:0] pat_bytes [MAX_PATTERN_BYTES];
   logic [ByteW-1:0] want [MAX_PATTERN_BYTES];
   logic [StreamW-1:0] stream;
   logic [ThrW-1:0]  thr [NumAlign];
   logic [NumAlign-1:0] align_hit;
   logic             hit_any;
   logic [ThrW-1:0]  thr_sel;
   logic [OffW-1:0]  offset_new;

   always_comb begin
      if (pattern_length_ff == '0) begin
         len_used = LenW'(1);
      end else if (pattern_length_ff > LenW'(MAX_PATTERN_BYTES)) begin
         len_used = LenW'(MAX_PATTERN_BYTES);
      end else begin
         len_used = pattern_length_ff;
      end
   end

   always_comb begin
      logic [StreamW-1:0] win;
      for (int q = 0; q < MAX_PATTERN_BYTES; q++) begin
         pat_bytes[q] = match_pattern_ff[ByteW*q +: ByteW];
      end
      // window byte q holds pattern byte len-1-q
      for (int q = 0; q < MAX_PATTERN_BYTES; q++) begin
         want[q] = '0;
         for (int c = 0; c < MAX_PATTERN_BYTES; c++) begin
            if (LenW'(c) == (len_used - LenW'(1) - LenW'(q))) begin
               want[q] = pat_bytes[c];
            end
         end
      end
      for (int i = 0; i < HistDepth; i++) begin
         stream[ByteW*i +: ByteW] = history_in[i];
      end
      for (int k = 0; k < NumAlign; k++) begin
         thr[k]       = ThrW'({len_used, 3'b000}) + ThrW'(k);
         win          = stream >> k;
         align_hit[k] = (bits_in >= OffW'(thr[k]));
         for (int q = 0; q < MAX_PATTERN_BYTES; q++) begin
            if ((LenW'(q) < len_used) && (win[ByteW*q +: ByteW] != want[q])) begin
               align_hit[k] = 1'b0;
            end
         end
      end
      // more trailing bits means an earlier start
      hit_any = 1'b0;
      thr_sel = thr[0];
      for (int k = 0; k < NumAlign; k++) begin
         if (align_hit[k]) begin
            hit_any = 1'b1;
            thr_sel = thr[k];
         end
      end
      offset_new = bits_in - OffW'(thr_sel);
   end

   // output register with skid entry
   logic            out_valid_ff;
   logic [OffW-1:0] out_data_ff;
   logic            skid_valid_ff;
   logic [OffW-1:0] skid_data_ff;
   logic            new_result;
   logic            out_take;

   assign new_result = req_accept && hit_any;
   assign out_take   = out_valid_ff && rsp_tready;
   assign req_tready = !skid_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || out_take) begin
         out_valid_ff <= new_result;
      end else if (new_result) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_take) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (!out_valid_ff || out_take) begin
         if (new_result) begin
            out_data_ff <= offset_new;
         end
      end else if (new_result) begin
         skid_data_ff <= offset_new;
      end
   end

endmodule

FILE: rtl/bapf_checker.sv
// ----------------------------------------------------------------------------
// bapf_port_checks
// Port-level checks for the bit-aligned pattern finder, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bit_aligned_pattern_finder_macros.svh"

module bapf_port_checks (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [bapf_pkg::OFFSET_W-1:0]    rsp_tdata
);

   logic req_beat;
   logic restart_idle;
   logic rsp_stall;
   assign req_beat     = req_tvalid && req_tready;
   assign restart_idle = req_beat && req_tuser && !rsp_tvalid;
   assign rsp_stall    = rsp_tvalid && !rsp_tready;

   // stalled result beat holds
   `BAPF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))

   // input only stalls while a result is pending
   `BAPF_ASSERT_IMPL(a_ready_backpressure, clock, reset, !req_tready, rsp_tvalid)

   // a restart beat can only match at offset zero
   `BAPF_ASSERT_NEXT(a_restart_offset, clock, reset, restart_idle, !rsp_tvalid || (rsp_tdata == '0))

   // no result straight out of reset
   `BAPF_ASSERT_IMPL(a_reset_quiet, clock, reset, $fell(reset), !rsp_tvalid)

endmodule

bind bit_aligned_pattern_finder bapf_port_checks u_bapf_port_checks (.*);
